[src/mei_pkg.sv]
// Shared types and constants for the escape-time iteration block.
// Used by mei_regs, mei_ctrl, mei_datapath and the top level.
`timescale 1ns / 1ps

package mei_pkg;

    localparam int COORD_W       = 32;
    localparam int COUNT_W       = 12;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int FRAC_BITS_DEF = 28;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_ITER = 1'b0;

    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 12'd128;

    typedef struct packed {
        logic load;     // capture c and start z = c
        logic step;     // commit new z, count + 1
        logic publish;  // move count into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic at_limit; // count has reached max_iterations
        logic escape;   // |z|^2 >= 4.0 or a component overflowed
    } t_dp_status;

endpackage

[src/mei_regs.sv]
// Configuration register file: max_iterations behind an APB-style port.
// Depends on mei_pkg.
`timescale 1ns / 1ps

module mei_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mei_pkg::PADDR_W-1:0]  paddr,
    input  logic [mei_pkg::PDATA_W-1:0]  pwdata,
    output logic [mei_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [mei_pkg::COUNT_W-1:0]  o_max_iterations
);

    logic [mei_pkg::COUNT_W-1:0] r_max_iter;
    logic                        sel_max_iter;

    assign sel_max_iter = (paddr[2] == mei_pkg::REG_MAX_ITER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= mei_pkg::MAX_ITER_RESET;
        end else if (psel && penable && pwrite && sel_max_iter) begin
            r_max_iter <= pwdata[mei_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_max_iter) begin
            prdata = {{(mei_pkg::PDATA_W-mei_pkg::COUNT_W){1'b0}}, r_max_iter};
        end
    end

    assign pready           = 1'b1;
    assign o_max_iterations = r_max_iter;

endmodule

[src/mei_datapath.sv]
// Datapath: z registers, product registers, iteration counter, output register.
// Depends on mei_pkg; driven by mei_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module mei_datapath #(
    parameter int FRAC_BITS = mei_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  mei_pkg::t_dp_cmd                    i_cmd,
    output mei_pkg::t_dp_status                 o_status,
    input  logic signed [mei_pkg::COORD_W-1:0]  i_c_real,
    input  logic signed [mei_pkg::COORD_W-1:0]  i_c_imag,
    input  logic        [mei_pkg::COUNT_W-1:0]  i_max_iterations,
    output logic        [mei_pkg::COUNT_W-1:0]  o_iteration_count
);

    localparam int CW = mei_pkg::COORD_W;
    localparam int PW = mei_pkg::PROD_W;
    localparam logic [PW-1:0] FOUR = PW'(1) << (2 * FRAC_BITS + 2);

    logic signed [CW-1:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [PW-1:0] r_sq_r, r_sq_i, r_cross;
    logic [mei_pkg::COUNT_W-1:0] r_count, r_out_count;
    logic r_ovf;

    logic [PW-1:0]        mag_sum;
    logic signed [PW-1:0] diff, n_r, n_i;
    logic                 n_ovf;

    // products of the current z; z only moves on step, so always capturing is safe
    always_ff @(posedge i_clk) begin
        r_sq_r  <= r_zr * r_zr;
        r_sq_i  <= r_zi * r_zi;
        r_cross <= r_zr * r_zi;
    end

    always_comb begin
        mag_sum = $unsigned(r_sq_r) + $unsigned(r_sq_i);
        diff    = r_sq_r - r_sq_i;
        // arithmetic shift gives floor rounding
        n_r     = (diff >>> FRAC_BITS) + PW'(r_cr);
        n_i     = (r_cross >>> (FRAC_BITS - 1)) + PW'(r_ci);
        n_ovf   = !((&n_r[PW-1:CW-1]) || !(|n_r[PW-1:CW-1])) ||
                  !((&n_i[PW-1:CW-1]) || !(|n_i[PW-1:CW-1]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr    <= i_c_real;
            r_ci    <= i_c_imag;
            r_zr    <= i_c_real;
            r_zi    <= i_c_imag;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.step) begin
            r_zr    <= n_r[CW-1:0];
            r_zi    <= n_i[CW-1:0];
            r_count <= r_count + 1'b1;
            r_ovf   <= n_ovf;
        end
        if (i_cmd.publish) begin
            r_out_count <= r_count;
        end
    end

    assign o_status.at_limit = (r_count >= i_max_iterations);
    assign o_status.escape   = r_ovf || (mag_sum >= FOUR);
    assign o_iteration_count = r_out_count;

endmodule

[src/mei_ctrl.sv]
// Controller: sequences multiply and evaluate phases, handles both handshakes.
// Depends on mei_pkg; commands mei_datapath.
`timescale 1ns / 1ps

module mei_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  mei_pkg::t_dp_status   i_status,
    output mei_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_HOLD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free, done;

    assign out_free = !r_out_valid || !i_out_stall;
    assign done     = i_status.at_limit || i_status.escape;

    always_comb begin
        o_cmd.load    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.step    = (r_state == ST_EVAL) && !done;
        o_cmd.publish = ((r_state == ST_EVAL) && done && out_free) ||
                        ((r_state == ST_HOLD) && out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (!done)          r_state <= ST_MUL;
                    else if (out_free)  r_state <= ST_IDLE;
                    else                r_state <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (out_free) r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[src/mandelbrot_escape_iteration.sv]
// Top level of the escape-time iteration block.
// Depends on mei_pkg, mei_regs, mei_ctrl and mei_datapath.
//
//   channel   handshake                   payload
//   input     i_in_valid / o_in_stall     i_c_real, i_c_imag (Q4.28 signed)
//   output    o_out_valid / i_out_stall   o_iteration_count
//   config    psel/penable/pwrite/pready  paddr, pwdata, prdata (max_iterations @ 0)
//
// Each iteration runs on the shared multiply/update unit in a multiply phase
// (products registered) and then an evaluate phase (escape test and update).
// Reset is synchronous, active low; max_iterations comes back as 128.
// A new point is taken as soon as the previous result sits in the output
// register; if that register is still stalled when the next result is ready,
// the block holds it and stalls the input.
`timescale 1ns / 1ps

module mandelbrot_escape_iteration #(
    parameter int FRAC_BITS = mei_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [mei_pkg::COORD_W-1:0]  i_c_real,
    input  logic signed [mei_pkg::COORD_W-1:0]  i_c_imag,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic        [mei_pkg::COUNT_W-1:0]  o_iteration_count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [mei_pkg::PADDR_W-1:0]  paddr,
    input  logic        [mei_pkg::PDATA_W-1:0]  pwdata,
    output logic        [mei_pkg::PDATA_W-1:0]  prdata,
    output logic                                pready
);

    logic [mei_pkg::COUNT_W-1:0] max_iterations;
    mei_pkg::t_dp_cmd            dp_cmd;
    mei_pkg::t_dp_status         dp_status;

    mei_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_max_iterations (max_iterations)
    );

    mei_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    mei_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_c_real          (i_c_real),
        .i_c_imag          (i_c_imag),
        .i_max_iterations  (max_iterations),
        .o_iteration_count (o_iteration_count)
    );

endmodule

[tb/sv/mandelbrot_escape_iteration_test.sv]
// Self-checking testbench for mandelbrot_escape_iteration: random points and limits,
// escape counts predicted in-bench and compared per result transfer.
// Depends on mei_pkg and the mandelbrot_escape_iteration RTL.
`timescale 1ns / 1ps

module mandelbrot_escape_iteration_test;

    localparam int          FRAC         = mei_pkg::FRAC_BITS_DEF;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          HOLD_CYCLES  = 3000;
    localparam int          IDLE_PCT     = 28;
    localparam int          SETTLE_CYCLES = 40;

    localparam logic [mei_pkg::PADDR_W-1:0] ADDR_MAX_ITER = {mei_pkg::REG_MAX_ITER, 2'b00};
    localparam logic [mei_pkg::PADDR_W-1:0] ADDR_UNMAPPED = {~mei_pkg::REG_MAX_ITER, 2'b00};

    localparam longint        Z_MIN = -64'sh8000_0000;
    localparam longint        Z_MAX = 64'sh7FFF_FFFF;
    localparam logic [63:0]   MAG_ESCAPE = 64'd1 << (2 * FRAC + 2);

    typedef struct packed {
        logic signed [mei_pkg::COORD_W-1:0] re_part;
        logic signed [mei_pkg::COORD_W-1:0] im_part;
    } t_point;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic signed [mei_pkg::COORD_W-1:0]   i_c_real = '0;
    logic signed [mei_pkg::COORD_W-1:0]   i_c_imag = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic [mei_pkg::COUNT_W-1:0]          o_iteration_count;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [mei_pkg::PADDR_W-1:0]          paddr = '0;
    logic [mei_pkg::PDATA_W-1:0]          pwdata = '0;
    logic [mei_pkg::PDATA_W-1:0]          prdata;
    logic                                 pready;

    t_point                       points_pending[$];
    logic [mei_pkg::COUNT_W-1:0]  counts_due[$];
    logic [mei_pkg::COUNT_W-1:0]  max_iter_model = mei_pkg::MAX_ITER_RESET;
    int                           mismatches = 0;
    int                           send_idle_pct = IDLE_PCT;
    int                           recv_idle_pct = IDLE_PCT;
    bit                           hold_req = 1'b0;
    bit                           hold_begun = 1'b0;
    int                           hold_left = 0;
    int unsigned                  cycle_count = 0;

    mandelbrot_escape_iteration i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_c_real          (i_c_real),
        .i_c_imag          (i_c_imag),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_iteration_count (o_iteration_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Escape-time count: exact double-width magnitude test, floor shifts,
    // imaginary update from the old real part.
    function automatic logic [mei_pkg::COUNT_W-1:0] escape_count(
        input logic signed [mei_pkg::COORD_W-1:0] cr,
        input logic signed [mei_pkg::COORD_W-1:0] ci,
        input logic        [mei_pkg::COUNT_W-1:0] limit);
        longint                      zr;
        longint                      zi;
        longint                      nr;
        longint                      ni;
        logic [63:0]                 abs_r;
        logic [63:0]                 abs_i;
        logic [mei_pkg::COUNT_W-1:0] n;
        bit                          ovf;
        zr = cr;
        zi = ci;
        n = '0;
        ovf = 1'b0;
        while (n < limit) begin
            if (ovf)
                break;
            abs_r = (zr < 0) ? -zr : zr;
            abs_i = (zi < 0) ? -zi : zi;
            if (abs_r * abs_r + abs_i * abs_i >= MAG_ESCAPE)
                break;
            n++;
            nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
            ni = ((zr * zi) >>> (FRAC - 1)) + ci;
            if (nr < Z_MIN || nr > Z_MAX || ni < Z_MIN || ni > Z_MAX)
                ovf = 1'b1;
            zr = nr;
            zi = ni;
        end
        return n;
    endfunction

    // Mostly points around the set, some in the seahorse valley, rest raw bits.
    function automatic t_point random_point();
        t_point p;
        int     sel;
        sel = $urandom_range(99);
        if (sel < 70) begin
            p.re_part = -32'sd603979776 + $urandom_range(805306368);
            p.im_part = -32'sd402653184 + $urandom_range(805306368);
        end else if (sel < 85) begin
            p.re_part = -32'sd214748365 + $urandom_range(26843546);
            p.im_part = $urandom_range(53687091);
        end else begin
            p.re_part = $urandom;
            p.im_part = $urandom;
        end
        return p;
    endfunction

    // input driver
    always @(posedge i_clk) begin : drive
        bit take_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                counts_due.push_back(escape_count(i_c_real, i_c_imag, max_iter_model));
                void'(points_pending.pop_front());
                take_next = 1'b1;
            end else begin
                take_next = !i_in_valid;
            end
            if (take_next) begin
                if (points_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_c_real   <= points_pending[0].re_part;
                    i_c_imag   <= points_pending[0].im_part;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_begun) begin
            hold_begun  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check
        logic [mei_pkg::COUNT_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (counts_due.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, got count %0d",
                         $time, o_iteration_count);
                mismatches++;
            end else begin
                want = counts_due.pop_front();
                if (o_iteration_count !== want) begin
                    $display("%0t: iteration_count expected %0d, got %0d",
                             $time, want, o_iteration_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d points pending, %0d results due",
                     $time, points_pending.size(), counts_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic apb_xfer(input logic wr, input logic [mei_pkg::PADDR_W-1:0] addr,
                            input logic [mei_pkg::PDATA_W-1:0] wdata,
                            output logic [mei_pkg::PDATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper data bits are random; only the low COUNT_W bits land in the register
    task automatic write_register(input logic [mei_pkg::PADDR_W-1:0] addr,
                                  input logic [mei_pkg::COUNT_W-1:0] value);
        logic [mei_pkg::PDATA_W-1:0] data;
        logic [mei_pkg::PDATA_W-1:0] unused;
        data = ($urandom & ~32'hFFF) | value;
        apb_xfer(1'b1, addr, data, unused);
        if (addr == ADDR_MAX_ITER)
            max_iter_model = data[mei_pkg::COUNT_W-1:0];
    endtask

    task automatic check_register();
        logic [mei_pkg::PDATA_W-1:0] data;
        apb_xfer(1'b0, ADDR_MAX_ITER, '0, data);
        if (data[mei_pkg::COUNT_W-1:0] !== max_iter_model) begin
            $display("%0t: max_iterations readback expected %0d, got %0d",
                     $time, max_iter_model, data[mei_pkg::COUNT_W-1:0]);
            mismatches++;
        end
    endtask

    task automatic drain();
        while (points_pending.size() != 0 || counts_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_batch(input logic [mei_pkg::COUNT_W-1:0] limit, input int n);
        write_register(ADDR_MAX_ITER, limit);
        check_register();
        @(negedge i_clk);
        repeat (n) points_pending.push_back(random_point());
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_register();

        // directed points at the reset limit: origin, exact |z|^2 = 4 on both
        // signs, one lsb inside, field extremes, cusp, period-2 point, i
        @(negedge i_clk);
        points_pending.push_back(t_point'{32'sh0000_0000, 32'sh0000_0000});
        points_pending.push_back(t_point'{32'sh2000_0000, 32'sh0000_0000});
        points_pending.push_back(t_point'{32'sh1FFF_FFFF, 32'sh0000_0000});
        points_pending.push_back(t_point'{-32'sh2000_0000, 32'sh0000_0000});
        points_pending.push_back(t_point'{-32'sh1FFF_FFFF, 32'sh0000_0000});
        points_pending.push_back(t_point'{32'sh0000_0000, 32'sh2000_0000});
        points_pending.push_back(t_point'{32'sh8000_0000, 32'sh8000_0000});
        points_pending.push_back(t_point'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        points_pending.push_back(t_point'{32'sh8000_0000, 32'sh0000_0000});
        points_pending.push_back(t_point'{32'sh0000_0000, 32'sh7FFF_FFFF});
        points_pending.push_back(t_point'{32'sh7FFF_FFFF, 32'sh8000_0000});
        points_pending.push_back(t_point'{32'sh0000_0001, 32'sh0000_0001});
        points_pending.push_back(t_point'{32'shFFFF_FFFF, 32'shFFFF_FFFF});
        points_pending.push_back(t_point'{32'sh0400_0000, 32'sh0000_0000});
        points_pending.push_back(t_point'{-32'sh1000_0000, 32'sh0000_0000});
        points_pending.push_back(t_point'{32'sh0000_0000, 32'sh1000_0000});
        points_pending.push_back(t_point'{-32'sh0C00_0000, 32'sh0199_9999});
        points_pending.push_back(t_point'{32'sh04CC_CCCC, 32'sh0800_0000});
        points_pending.push_back(t_point'{32'sh16A0_9E66, 32'sh16A0_9E66});
        points_pending.push_back(t_point'{-32'sh1800_0000, 32'sh0000_0000});
        points_pending.push_back(t_point'{32'sh0200_0000, -32'sh1000_0000});
        drain();

        // zero limit, then a write to an unmapped address must leave it alone
        run_batch(12'd0, 6);
        write_register(ADDR_UNMAPPED, mei_pkg::COUNT_W'($urandom_range(4095)));
        check_register();

        run_batch(12'd1, 80);
        run_batch(12'd4095, 8);

        // long output hold-off so the block backs up into the input
        hold_req = 1'b1;
        run_batch(12'd12, 150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_batch(12'd128, 200);
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;

        run_batch(12'd300, 100);
        run_batch(12'd1000, 40);
        run_batch(12'd50, 80);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
